### sv/order_points_clockwise_top_assert.svh
// assertion macros for the clockwise point ordering block
// used by order_points_clockwise_top; expects i_clk and i_rst_n in scope
`ifndef ORDER_POINTS_CLOCKWISE_TOP_ASSERT_SVH
`define ORDER_POINTS_CLOCKWISE_TOP_ASSERT_SVH

// same-cycle implication
`define OPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/opc_pkg.sv
// shared constants and helpers for the clockwise point ordering block
// no dependencies
package opc_pkg;

    localparam int OPC_MAX_POINTS = 16;
    localparam int OPC_IDX_W      = 24;
    localparam int OPC_PPR_W      = 13;
    localparam int OPC_PADDR_W    = 3;
    localparam int OPC_PDATA_W    = 32;

    // register indexes
    localparam logic OPC_REG_PPR = 1'b0;

    // angle classes, ordered by increasing angle
    typedef logic [1:0] t_cls;
    localparam t_cls CLS_LOW  = 2'd0;  // column offset negative
    localparam t_cls CLS_AXIS = 2'd1;  // on the positive row axis or zero offset
    localparam t_cls CLS_HIGH = 2'd2;  // column offset positive or negative row axis

    function automatic t_cls opc_class(input logic y_neg, input logic y_zero,
                                       input logic x_neg);
        t_cls c;
        if (y_neg) begin
            c = CLS_LOW;
        end else if (y_zero && !x_neg) begin
            c = CLS_AXIS;
        end else begin
            c = CLS_HIGH;
        end
        return c;
    endfunction

endpackage

### sv/order_points_clockwise_top.sv
// clockwise ordering of the points of one convex grid face
// depends on opc_pkg and order_points_clockwise_top_assert.svh
//
// usage:
//   s_axis carries one grid index per transfer (tdata), tlast marks the final
//   point of a face. points beyond MAX_POINTS are dropped, a dropped tlast
//   still closes the face. after the last point the block splits every index
//   into column and row with a bit-serial divider, then ranks each point
//   against all others by angle about the centroid (n*n pairs). the rank
//   compare and its two cross products are what set the run time. results
//   leave on m_axis in descending angle order, tlast on the final one, each
//   held back while the output register still holds an untaken result.
//   s_axis is not ready from the last input until the final result is loaded.
//   a stalled m_axis holds its output register; the next face loads as soon
//   as the final result sits in that register.
//   apb register 0 (byte 0): points_per_row, 13 bits, zero acts as one.
//   reset (synchronous, active low) empties the face, clears the output
//   valid and sets points_per_row to one. the point memories need no
//   clearing: only entries written for the current face are read.
module order_points_clockwise_top
    import opc_pkg::*;
#(
    parameter int MAX_POINTS = OPC_MAX_POINTS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream: tdata = point_index[23:0]
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [OPC_IDX_W-1:0]   s_axis_tdata,
    input  logic                   s_axis_tlast,
    // master stream: tdata = sorted_index[23:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OPC_IDX_W-1:0]   m_axis_tdata,
    output logic                   m_axis_tlast,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [OPC_PADDR_W-1:0] paddr,
    input  logic [OPC_PDATA_W-1:0] pwdata,
    output logic [OPC_PDATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int STEP_W = $clog2(OPC_IDX_W);
    localparam int RSUM_W = OPC_IDX_W + CNT_W;
    localparam int CSUM_W = OPC_PPR_W + CNT_W;
    localparam int OFFR_W = RSUM_W + 1;
    localparam int OFFC_W = CSUM_W + 1;
    localparam int PROD_W = OFFR_W + OFFC_W;
    localparam int MEM_W  = 2 * OPC_IDX_W + OPC_PPR_W;

    typedef enum logic [11:0] {
        S_LOAD    = 12'b000000000001,
        S_DIV_RD  = 12'b000000000010,
        S_DIV_LD  = 12'b000000000100,
        S_DIV_RUN = 12'b000000001000,
        S_RK_RDI  = 12'b000000010000,
        S_RK_OFI  = 12'b000000100000,
        S_RK_RDJ  = 12'b000001000000,
        S_RK_OFJ  = 12'b000010000000,
        S_RK_MUL  = 12'b000100000000,
        S_RK_CMP  = 12'b001000000000,
        S_EM_RD   = 12'b010000000000,
        S_EM_WR   = 12'b100000000000
    } t_state;

    t_state                r_state;
    logic [OPC_PPR_W-1:0]  r_ppr;
    logic [CNT_W-1:0]      r_count, r_n, r_i, r_j, r_k, r_rank;
    logic [CSUM_W-1:0]     r_csum;
    logic [RSUM_W-1:0]     r_rsum;
    // divider
    logic [OPC_IDX_W-1:0]  r_idx, r_dvd;
    logic [OPC_PPR_W-1:0]  r_rem;
    logic [STEP_W-1:0]     r_step;
    // ranking
    logic [OPC_IDX_W-1:0]  r_aidx;
    logic signed [OFFR_W-1:0] r_ar, r_br;
    logic signed [OFFC_W-1:0] r_ac, r_bc;
    logic signed [PROD_W-1:0] r_p1, r_p2;
    // output register
    logic                  r_ovalid, r_olast;
    logic [OPC_IDX_W-1:0]  r_odata;

    // point memory: {index, column, row}, sorted memory: index by rank
    logic [MEM_W-1:0]      pmem [MAX_POINTS];
    logic [OPC_IDX_W-1:0]  smem [MAX_POINTS];
    logic [MEM_W-1:0]      r_prd;
    logic [OPC_IDX_W-1:0]  r_srd;

    logic                  w_sacc, w_we, w_cfg_wr, w_div_last;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [MEM_W-1:0]      w_wdata;
    logic [OPC_PPR_W-1:0]  w_div, n_rem;
    logic [OPC_PPR_W:0]    w_tmp, w_diff;
    logic [OPC_IDX_W-1:0]  n_dvd;
    logic [CNT_W-1:0]      n_count, n_rank;
    logic [RSUM_W-1:0]     w_nrow;
    logic [CSUM_W-1:0]     w_ncol;
    logic signed [OFFR_W-1:0] w_offr;
    logic signed [OFFC_W-1:0] w_offc;
    t_cls                  w_ci, w_cj;
    logic                  w_gt, w_eq, w_before;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == OPC_REG_PPR)
                    ? {{(OPC_PDATA_W-OPC_PPR_W){1'b0}}, r_ppr} : '0;

    assign s_axis_tready = (r_state == S_LOAD);
    assign w_sacc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    assign n_count = (r_count < CNT_W'(MAX_POINTS)) ? r_count + 1'b1 : r_count;

    // restoring divide, one quotient bit a cycle
    assign w_div      = (r_ppr == '0) ? OPC_PPR_W'(1) : r_ppr;
    assign w_tmp      = {r_rem, r_dvd[OPC_IDX_W-1]};
    assign w_diff     = w_tmp - {1'b0, w_div};
    assign n_rem      = (w_tmp >= {1'b0, w_div}) ? w_diff[OPC_PPR_W-1:0]
                                                 : w_tmp[OPC_PPR_W-1:0];
    assign n_dvd      = {r_dvd[OPC_IDX_W-2:0], (w_tmp >= {1'b0, w_div})};
    assign w_div_last = (r_state == S_DIV_RUN) && (r_step == STEP_W'(OPC_IDX_W - 1));

    // memory write and read address
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = {s_axis_tdata, {OPC_PPR_W{1'b0}}, {OPC_IDX_W{1'b0}}};
        if (w_sacc && (r_count < CNT_W'(MAX_POINTS))) begin
            w_we = 1'b1;
        end else if (w_div_last) begin
            w_we    = 1'b1;
            w_waddr = r_i[AW-1:0];
            w_wdata = {r_idx, n_rem, n_dvd};
        end
    end
    assign w_raddr = (r_state == S_RK_RDJ) ? r_j[AW-1:0] : r_i[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            pmem[w_waddr] <= w_wdata;
        end
        r_prd <= pmem[w_raddr];
    end

    // offsets scaled by the point count, centroid without division
    assign w_nrow = r_n * r_prd[OPC_IDX_W-1:0];
    assign w_ncol = r_n * r_prd[OPC_IDX_W+OPC_PPR_W-1:OPC_IDX_W];
    assign w_offr = signed'({1'b0, w_nrow}) - signed'({1'b0, r_rsum});
    assign w_offc = signed'({1'b0, w_ncol}) - signed'({1'b0, r_csum});

    // point j goes before point i on a greater angle, or an equal one and earlier arrival
    assign w_ci     = opc_class(r_ac < 0, r_ac == '0, r_ar < 0);
    assign w_cj     = opc_class(r_bc < 0, r_bc == '0, r_br < 0);
    assign w_gt     = (w_cj > w_ci) || ((w_cj == w_ci) && (w_ci != CLS_AXIS) && (r_p1 > r_p2));
    assign w_eq     = (w_cj == w_ci) && ((w_ci == CLS_AXIS) || (r_p1 == r_p2));
    assign w_before = w_gt || (w_eq && (r_j < r_i));
    assign n_rank   = r_rank + CNT_W'(w_before);

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RK_CMP) && (r_j == r_n - 1'b1)) begin
            smem[n_rank[AW-1:0]] <= r_aidx;
        end
        r_srd <= smem[r_k[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ppr    <= OPC_PPR_W'(1);
            r_count  <= '0;
            r_csum   <= '0;
            r_rsum   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_cfg_wr && (paddr[2] == OPC_REG_PPR)) begin
                r_ppr <= pwdata[OPC_PPR_W-1:0];
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_sacc) begin
                        r_count <= n_count;
                        if (s_axis_tlast) begin
                            r_n     <= n_count;
                            r_i     <= '0;
                            r_state <= S_DIV_RD;
                        end
                    end
                end
                S_DIV_RD: begin
                    r_state <= S_DIV_LD;
                end
                S_DIV_LD: begin
                    r_idx   <= r_prd[MEM_W-1:MEM_W-OPC_IDX_W];
                    r_dvd   <= r_prd[MEM_W-1:MEM_W-OPC_IDX_W];
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV_RUN;
                end
                S_DIV_RUN: begin
                    r_rem  <= n_rem;
                    r_dvd  <= n_dvd;
                    r_step <= r_step + 1'b1;
                    if (w_div_last) begin
                        r_csum <= r_csum + CSUM_W'(n_rem);
                        r_rsum <= r_rsum + RSUM_W'(n_dvd);
                        if (r_i == r_n - 1'b1) begin
                            r_i     <= '0;
                            r_state <= S_RK_RDI;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_DIV_RD;
                        end
                    end
                end
                S_RK_RDI: begin
                    r_state <= S_RK_OFI;
                end
                S_RK_OFI: begin
                    r_aidx  <= r_prd[MEM_W-1:MEM_W-OPC_IDX_W];
                    r_ar    <= w_offr;
                    r_ac    <= w_offc;
                    r_j     <= '0;
                    r_rank  <= '0;
                    r_state <= S_RK_RDJ;
                end
                S_RK_RDJ: begin
                    r_state <= S_RK_OFJ;
                end
                S_RK_OFJ: begin
                    r_br    <= w_offr;
                    r_bc    <= w_offc;
                    r_state <= S_RK_MUL;
                end
                S_RK_MUL: begin
                    // cross product terms of the angle compare
                    r_p1    <= PROD_W'(r_ar) * PROD_W'(r_bc);
                    r_p2    <= PROD_W'(r_ac) * PROD_W'(r_br);
                    r_state <= S_RK_CMP;
                end
                S_RK_CMP: begin
                    r_rank <= n_rank;
                    if (r_j == r_n - 1'b1) begin
                        if (r_i == r_n - 1'b1) begin
                            r_k     <= '0;
                            r_state <= S_EM_RD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RK_RDI;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RK_RDJ;
                    end
                end
                S_EM_RD: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_state <= S_EM_WR;
                    end
                end
                S_EM_WR: begin
                    r_ovalid <= 1'b1;
                    r_odata  <= r_srd;
                    r_olast  <= (r_k == r_n - 1'b1);
                    if (r_k == r_n - 1'b1) begin
                        r_count <= '0;
                        r_csum  <= '0;
                        r_rsum  <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_EM_RD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

`include "order_points_clockwise_top_assert.svh"

    `OPC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_POINTS), "point count overflow")
    `OPC_ASSERT_NEXT(a_last_closes, w_sacc && s_axis_tlast, !s_axis_tready, "face not closed")
    `OPC_ASSERT_NOW(a_rank_bound, r_state == S_RK_CMP, r_rank < r_n, "rank out of range")
    `OPC_ASSERT_NOW(a_emit_room, r_state == S_EM_WR, !r_ovalid, "output register overwritten")

endmodule

### sim/order_points_clockwise_top_tb.sv
// testbench for order_points_clockwise_top: faces of grid points go in,
// clockwise-ordered indices come out; checked against a built-in predictor
// depends on opc_pkg and the order_points_clockwise_top rtl
`timescale 1ns / 1ps

module order_points_clockwise_top_tb;
    import opc_pkg::*;

    localparam int NPT = OPC_MAX_POINTS;

    typedef struct packed {
        logic [OPC_IDX_W-1:0] index;
        logic                 last;
    } t_point;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OPC_IDX_W-1:0]   s_axis_tdata = '0;   // point_index[23:0]
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OPC_IDX_W-1:0]   m_axis_tdata;        // sorted_index[23:0]
    logic                   m_axis_tlast;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [OPC_PADDR_W-1:0] paddr = '0;
    logic [OPC_PDATA_W-1:0] pwdata = '0;
    logic [OPC_PDATA_W-1:0] prdata;
    logic                   pready;

    order_points_clockwise_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [OPC_PPR_W-1:0] row_len = 1;
    logic [OPC_IDX_W-1:0] face_pts [NPT];
    int                   face_n = 0;

    t_point pending_pts[$];   // stimulus waiting for the driver
    t_point ordered_pts[$];   // predicted results, oldest first
    int     errors = 0;
    bit     hold_req = 1'b0;  // asks the receiver for one long stall
    int     hold_cnt = 0;     // cycles of that stall so far
    bit     in_taken = 1'b0;  // input transfer at the last rising edge

    // angle class: 0 below, 1 on the positive axis or zero, 2 above
    function automatic int ang_class(longint x, longint y);
        if (y < 0) return 0;
        if (y == 0 && x >= 0) return 1;
        return 2;
    endfunction

    function automatic bit ang_gt(longint ax, longint ay, longint bx, longint by);
        int ca, cb;
        ca = ang_class(ax, ay);
        cb = ang_class(bx, by);
        if (ca != cb) return ca > cb;
        if (ca == 1) return 1'b0;
        return bx * ay - by * ax > 0;
    endfunction

    // take one accepted point; on the last one queue the ordered face
    task automatic predict_face(input t_point p);
        longint ppr, csum, rsum, dc, dr;
        longint oc [NPT];
        longint orw [NPT];
        logic [OPC_IDX_W-1:0] v;
        int j;
        if (face_n < NPT) begin
            face_pts[face_n] = p.index;
            face_n++;
        end
        if (!p.last) return;
        if (face_n >= 2) begin
            ppr = (row_len == 0) ? 1 : longint'(row_len);
            csum = 0;
            rsum = 0;
            for (int i = 0; i < face_n; i++) begin
                csum += face_pts[i] % ppr;
                rsum += face_pts[i] / ppr;
            end
            for (int i = 0; i < face_n; i++) begin
                oc[i] = face_n * (face_pts[i] % ppr) - csum;
                orw[i] = face_n * (face_pts[i] / ppr) - rsum;
            end
            // stable insertion sort, descending angle (x = row, y = column)
            for (int i = 1; i < face_n; i++) begin
                v = face_pts[i];
                dc = oc[i];
                dr = orw[i];
                j = i;
                while (j > 0 && ang_gt(dr, dc, orw[j-1], oc[j-1])) begin
                    face_pts[j] = face_pts[j-1];
                    oc[j] = oc[j-1];
                    orw[j] = orw[j-1];
                    j--;
                end
                face_pts[j] = v;
                oc[j] = dc;
                orw[j] = dr;
            end
        end
        for (int k = 0; k < face_n; k++)
            ordered_pts.push_back('{index: face_pts[k], last: (k + 1 == face_n)});
        face_n = 0;
    endtask

    // driver: bursts and gaps, changes on the falling edge
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            // offer held until accepted
        end else if (gap_left > 0 || pending_pts.size() == 0) begin
            s_axis_tvalid <= 1'b0;
            if (gap_left > 0) gap_left--;
        end else begin
            t_point p;
            p = pending_pts.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= p.index;
            s_axis_tlast  <= p.last;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end else begin
                burst_left--;
            end
        end
    end

    // receiver stall pattern, with one long stall counted here
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_req && hold_cnt < 3000) begin
            hold_cnt <= hold_cnt + 1;
            m_axis_tready <= 1'b0;
        end else if (stall_phase[8])
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    // monitor: input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_face('{index: s_axis_tdata, last: s_axis_tlast});
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ordered_pts.size() == 0) begin
                $error("unexpected result sorted_index=%0d", m_axis_tdata);
                errors++;
            end else begin
                t_point e;
                e = ordered_pts.pop_front();
                if (m_axis_tdata !== e.index) begin
                    $error("sorted_index expected %0d actual %0d", e.index, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_out expected %0d actual %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic write_row_len(input logic [OPC_PPR_W-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= OPC_PADDR_W'(4 * OPC_REG_PPR);
        pwdata <= OPC_PDATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        row_len = val;
    endtask

    // wait until all stimulus went in and all results came out
    task automatic drain();
        while (pending_pts.size() != 0 || s_axis_tvalid || ordered_pts.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic push_face(input int n, input int ppr_lim);
        logic [OPC_IDX_W-1:0] v;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: v = OPC_IDX_W'($urandom);
                1: v = OPC_IDX_W'($urandom_range(0, 15));
                default: v = OPC_IDX_W'($urandom_range(0, ppr_lim * 6));
            endcase
            pending_pts.push_back('{index: v, last: (i == n - 1)});
        end
    endtask

    logic [OPC_PPR_W-1:0] row_lens[] = '{0, 1, 5, 64, 4095, 8191};

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: square around a centroid, extremes, ties, overflow
        write_row_len(10);
        pending_pts.push_back('{index: 0, last: 0});
        pending_pts.push_back('{index: 9, last: 0});
        pending_pts.push_back('{index: 99, last: 0});
        pending_pts.push_back('{index: 90, last: 1});
        pending_pts.push_back('{index: 24'hFFFFFF, last: 1});       // single point
        pending_pts.push_back('{index: 24'hFFFFFF, last: 0});
        pending_pts.push_back('{index: 0, last: 1});
        pending_pts.push_back('{index: 55, last: 0});                // equal points
        pending_pts.push_back('{index: 55, last: 1});
        pending_pts.push_back('{index: 12, last: 0});                // collinear
        pending_pts.push_back('{index: 13, last: 0});
        pending_pts.push_back('{index: 14, last: 1});
        drain();
        write_row_len(0);
        push_face(18, 1);                                            // overflow face
        drain();

        // random phases across row lengths; one face under a long stall
        foreach (row_lens[r]) begin
            write_row_len(row_lens[r]);
            for (int f = 0; f < 5; f++)
                push_face(($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
                                                      : $urandom_range(1, 7),
                          (row_lens[r] == 0) ? 1 : row_lens[r]);
            if (r == 2) begin
                hold_req = 1'b1;
                wait (hold_cnt == 3000);
                hold_req = 1'b0;
            end
            drain();
        end
        write_row_len(OPC_PPR_W'($urandom_range(1, 4096)));
        for (int f = 0; f < 6; f++) push_face($urandom_range(1, 8), 4096);
        drain();

        if (errors == 0)
            $display("order_points_clockwise_top test passed");
        else
            $display("order_points_clockwise_top test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("order_points_clockwise_top test failed");
        $finish;
    end

endmodule
